// ----- src/csma_pkg.sv -----
`default_nettype none

package csma_pkg;

  // Widest backoff counter the parameter may ask for
  localparam int unsigned CW_BITS_DEF = 10;
  localparam int unsigned CW_BITS_MAX = 16;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IFS_TICKS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EIFS_TICKS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOT_TICKS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CW_MIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CW_MAX     = 3'd4;

  // Request kinds
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_MEDIUM = 3'd1;
  localparam logic [2:0] REQ_RADIO  = 3'd2;
  localparam logic [2:0] REQ_FCS    = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  // Access states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DEFER    = 3'd1;
  localparam logic [2:0] ST_BACKOFF  = 3'd2;
  localparam logic [2:0] ST_TRANSMIT = 3'd3;
  localparam logic [2:0] ST_WAIT_IFS = 3'd4;

  typedef struct packed {
    logic [15:0] ifs_ticks;
    logic [15:0] eifs_ticks;
    logic [9:0]  slot_ticks;
    logic [9:0]  cw_min;
    logic [9:0]  cw_max;
  } cfg_t;

  typedef struct packed {
    logic [9:0] backoff_draw;
    logic [3:0] retry_count;
    logic       fcs_ok;
    logic       tx_idle;
    logic       medium_free;
  } req_t;

  typedef struct packed {
    logic       start_rejected;
    logic       tx_complete;
    logic       send_frame;
    logic [2:0] access_state;
  } res_t;

endpackage

`default_nettype wire

// ----- src/csma_cfg.sv -----
`default_nettype none

module csma_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [csma_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [csma_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output csma_pkg::cfg_t                        cfg_o
);
  import csma_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IFS_TICKS:  cfg_d.ifs_ticks  = cfg_wdata_i;
        REG_EIFS_TICKS: cfg_d.eifs_ticks = cfg_wdata_i;
        REG_SLOT_TICKS: cfg_d.slot_ticks = cfg_wdata_i[9:0];
        REG_CW_MIN:     cfg_d.cw_min     = cfg_wdata_i[9:0];
        REG_CW_MAX:     cfg_d.cw_max     = cfg_wdata_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ifs_ticks  <= 16'd34;
      cfg_q.eifs_ticks <= 16'd94;
      cfg_q.slot_ticks <= 10'd9;
      cfg_q.cw_min     <= 10'd15;
      cfg_q.cw_max     <= 10'd1023;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/csma_core.sv -----
`default_nettype none

module csma_core #(
  parameter int unsigned CW_BITS = csma_pkg::CW_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [2:0]    req_type_i,
  input  csma_pkg::req_t     req_i,
  input  csma_pkg::cfg_t     cfg_i,
  output csma_pkg::res_t     res_o
);
  import csma_pkg::*;

  logic [2:0]         fsm_q, fsm_d;
  logic [CW_BITS-1:0] slots_left_q, slots_left_d;
  logic [9:0]         slot_timer_q, slot_timer_d;
  logic [15:0]        ifs_left_q, ifs_left_d;
  logic [15:0]        eifs_left_q, eifs_left_d;
  logic [15:0]        free_time_q, free_time_d;
  logic               eifs_pending_q, eifs_pending_d;
  logic               medium_free_q, medium_free_d;
  logic               radio_idle_q, radio_idle_d;

  // Contention window and backoff draw
  logic [25:0]           cw_full;
  logic [9:0]            cw_cap;
  logic [CW_BITS_MAX-1:0] slots_wide;
  logic [CW_BITS-1:0]    slots_new;

  always_comb begin
    cw_full    = ({15'd0, ({1'b0, cfg_i.cw_min} + 11'd1)} << req_i.retry_count) - 26'd1;
    cw_cap     = (cw_full > {16'd0, cfg_i.cw_max}) ? cfg_i.cw_max : cw_full[9:0];
    slots_wide = {{(CW_BITS_MAX-10){1'b0}}, req_i.backoff_draw & cw_cap};
    slots_new  = slots_wide[CW_BITS-1:0];
  end

  // IFS/EIFS load values; a medium change restarts the free-time count first
  logic [15:0] ft_eff, ifs_wait, eifs_wait;
  logic        eifs_load, ifs_needed;

  always_comb begin
    ft_eff     = (req_type_i == REQ_MEDIUM) ? 16'd0 : free_time_q;
    ifs_wait   = (cfg_i.ifs_ticks > ft_eff) ? cfg_i.ifs_ticks - ft_eff : 16'd0;
    eifs_wait  = cfg_i.eifs_ticks - ft_eff;
    eifs_load  = eifs_pending_q && (cfg_i.eifs_ticks > ft_eff);
    ifs_needed = (free_time_q < cfg_i.ifs_ticks) ||
                 (eifs_pending_q && (free_time_q < cfg_i.eifs_ticks));
  end

  logic [10:0] timer_inc;
  logic        send, done, rejected;

  always_comb begin
    fsm_d          = fsm_q;
    slots_left_d   = slots_left_q;
    slot_timer_d   = slot_timer_q;
    ifs_left_d     = ifs_left_q;
    eifs_left_d    = eifs_left_q;
    free_time_d    = free_time_q;
    eifs_pending_d = eifs_pending_q;
    medium_free_d  = medium_free_q;
    radio_idle_d   = radio_idle_q;
    send           = 1'b0;
    done           = 1'b0;
    rejected       = 1'b0;
    timer_inc      = {1'b0, slot_timer_q} + 11'd1;

    unique case (req_type_i) inside
      REQ_START: begin
        if (fsm_q != ST_IDLE) begin
          rejected = 1'b1;
        end else begin
          slots_left_d = slots_new;
          if (!medium_free_q) begin
            fsm_d = ST_DEFER;
          end else if (ifs_needed) begin
            fsm_d          = ST_WAIT_IFS;
            ifs_left_d     = ifs_wait;
            eifs_pending_d = 1'b0;
            if (eifs_load) eifs_left_d = eifs_wait;
          end else begin
            fsm_d = ST_TRANSMIT;
            send  = 1'b1;
          end
        end
      end
      REQ_MEDIUM, REQ_RADIO: begin
        if (req_type_i == REQ_MEDIUM) begin
          medium_free_d = req_i.medium_free;
          free_time_d   = 16'd0;
          if (!req_i.medium_free) eifs_left_d = 16'd0;
        end else begin
          radio_idle_d = req_i.tx_idle;
        end
        unique case (fsm_q)
          ST_DEFER: begin
            if (medium_free_d) begin
              fsm_d          = ST_WAIT_IFS;
              ifs_left_d     = ifs_wait;
              eifs_pending_d = 1'b0;
              if (eifs_load) eifs_left_d = eifs_wait;
            end
          end
          ST_WAIT_IFS: begin
            if (!medium_free_d) begin
              ifs_left_d = 16'd0;
              fsm_d      = ST_DEFER;
            end
          end
          ST_BACKOFF: begin
            if (!medium_free_d) begin
              slot_timer_d = 10'd0;
              fsm_d        = ST_DEFER;
            end
          end
          ST_TRANSMIT: begin
            if (radio_idle_d) begin
              fsm_d = ST_IDLE;
              done  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_FCS: eifs_pending_d = !req_i.fcs_ok;
      REQ_TICK: begin
        if (free_time_q != 16'hFFFF) free_time_d = free_time_q + 16'd1;
        if (ifs_left_q != 16'd0)     ifs_left_d  = ifs_left_q - 16'd1;
        if (eifs_left_q != 16'd0)    eifs_left_d = eifs_left_q - 16'd1;
        if (fsm_q == ST_WAIT_IFS) begin
          if (ifs_left_d == 16'd0 && eifs_left_d == 16'd0) begin
            fsm_d        = ST_BACKOFF;
            slot_timer_d = 10'd0;
            if (slots_left_q == '0) begin
              fsm_d = ST_TRANSMIT;
              send  = 1'b1;
            end
          end
        end else if (fsm_q == ST_BACKOFF) begin
          if (slots_left_q == '0) begin
            fsm_d = ST_TRANSMIT;
            send  = 1'b1;
          end else if (timer_inc >= {1'b0, cfg_i.slot_ticks}) begin
            // slot boundary; slot length zero behaves as one tick
            slot_timer_d = 10'd0;
            slots_left_d = slots_left_q - {{(CW_BITS-1){1'b0}}, 1'b1};
            if (slots_left_d == '0) begin
              fsm_d = ST_TRANSMIT;
              send  = 1'b1;
            end
          end else begin
            slot_timer_d = timer_inc[9:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q          <= ST_IDLE;
      slots_left_q   <= '0;
      slot_timer_q   <= '0;
      ifs_left_q     <= '0;
      eifs_left_q    <= '0;
      free_time_q    <= '0;
      eifs_pending_q <= 1'b0;
      medium_free_q  <= 1'b0;
      radio_idle_q   <= 1'b1;
    end else if (accept_i) begin
      fsm_q          <= fsm_d;
      slots_left_q   <= slots_left_d;
      slot_timer_q   <= slot_timer_d;
      ifs_left_q     <= ifs_left_d;
      eifs_left_q    <= eifs_left_d;
      free_time_q    <= free_time_d;
      eifs_pending_q <= eifs_pending_d;
      medium_free_q  <= medium_free_d;
      radio_idle_q   <= radio_idle_d;
    end
  end

  assign res_o.access_state   = fsm_d;
  assign res_o.send_frame     = send;
  assign res_o.tx_complete    = done;
  assign res_o.start_rejected = rejected;

  a_send_in_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && send |-> fsm_d == ST_TRANSMIT)
    else $error("send_frame without entering transmit");

  a_done_from_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |-> fsm_q == ST_TRANSMIT && radio_idle_d)
    else $error("tx_complete outside transmit");

  a_state_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> fsm_q == $past(res_o.access_state))
    else $error("state register differs from reported state");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && rejected |=> $stable(slots_left_q) && $stable(fsm_q))
    else $error("rejected start changed backoff state");

endmodule

`default_nettype wire

// ----- src/csma_ca_channel_access_fsm.sv -----
// Latency: a result appears on m_axis the cycle after its item is accepted on s_axis.
// Throughput: one item per cycle; the next-state logic is a single stage feeding
// the result register, which frees up in the cycle the sink takes it.
// Reset (rst_ni low, async): access state idle, timers and counters zero,
// medium busy, radio idle, registers at their defaults, no result held.
`default_nettype none

module csma_ca_channel_access_fsm #(
  parameter int unsigned CW_BITS = csma_pkg::CW_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [csma_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [csma_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // medium_free, tx_idle, fcs_ok, retry_count[3:0], backoff_draw[9:0], zero pad
  input  wire logic [csma_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type[2:0]
  input  wire logic [csma_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // access_state[2:0], send_frame, tx_complete, start_rejected, zero pad
  output      logic [csma_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import csma_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t res;
  res_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign req           = s_axis_tdata[$bits(req_t)-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  csma_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  csma_core #(
    .CW_BITS (CW_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (s_axis_tuser),
    .req_i      (req),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (accept) begin
      out_valid_d = 1'b1;
      res_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-$bits(res_t)){1'b0}}, res_q};

endmodule

`default_nettype wire
